@@ src/fct_pkg.sv @@
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants for the chain table engine: table geometry,
// command and status codes, transaction payload structs.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int MAX_BLOCKS = 8192;
  localparam int IDX_W      = 13;
  localparam int CNT_W      = 14;
  localparam int LINK_W     = 16;

  localparam logic [LINK_W-1:0] FAT_EOC    = 16'hFFFF;
  localparam logic [CNT_W-1:0]  BLOCKS_MAX = 14'd8192;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_FIND  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_EOC = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [LINK_W-1:0] entry_index;
    logic [LINK_W-1:0] entry_value;
  } fct_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  found_index;
    logic [LINK_W-1:0] read_value;
    logic [CNT_W-1:0]  freed_count;
  } fct_out_t;

endpackage

@@ src/fct_ram.sv @@
// ----------------------------------------------------------------------------
// fct_ram
// Generic single-write, single-read RAM with registered read data
// (read returns the contents before a same-cycle write).
// ----------------------------------------------------------------------------
module fct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ src/fat_chain_table_engine_top.sv @@
// ----------------------------------------------------------------------------
// fat_chain_table_engine_top
// FAT16-style link table with write, read, free-chain and find-free commands.
//
// Commands arrive on the in_ channel (valid/ready); one result transaction per
// command leaves on the out_ channel through an output register, so a command
// may be accepted while the previous result still waits for out_ready.
// The block takes one command at a time and is not ready while it works.
// States from accept to result valid:
//   write entry / range error : S_FIN, then the output register
//   read entry                : S_RDW (table read data), then S_FIN
//   free chain                : S_FREE once per entry cleared, then S_FIN
//   find free                 : S_SCAN reads entries in index order up to the
//                               first free one (or to the end if full), then S_FIN
// The walks are bound by the single table RAM port pair, one entry per cycle.
// A result held back by out_ready low stalls the block in its final state.
// block_count is written through the APB port at address 0 (reset 8192,
// saturated to 8192); write it only while idle.
// Reset clears control state only; table contents are undefined until written
// and the table must be loaded before use.
// ----------------------------------------------------------------------------
module fat_chain_table_engine_top (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fct_pkg::fct_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fct_pkg::fct_out_t out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  import fct_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDW  = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic             out_valid_r, out_valid_nxt;
  fct_out_t         out_data_r, out_data_nxt;
  fct_out_t         res_r, res_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic             byp_r, byp_nxt;
  logic [CNT_W-1:0] freed_r, freed_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;

  logic [CNT_W-1:0]  n_act;
  logic              in_rng;
  logic [LINK_W-1:0] link;
  logic [CNT_W-1:0]  freed_inc;
  logic              cfg_wr;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [LINK_W-1:0] ram_rdata;

  fct_ram #(
    .WIDTH(LINK_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign n_act     = (bc_r > BLOCKS_MAX) ? BLOCKS_MAX : bc_r;
  assign in_rng    = in_data.entry_index < {2'b00, n_act};
  assign link      = byp_r ? '0 : ram_rdata;
  assign freed_inc = freed_r + 1'b1;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, bc_r} : 32'd0;
  assign bc_nxt = cfg_wr ? pwdata[CNT_W-1:0] : bc_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    cur_nxt       = cur_r;
    byp_nxt       = byp_r;
    freed_nxt     = freed_r;
    scan_nxt      = scan_r;
    pend_vld_nxt  = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    ram_we        = 1'b0;
    ram_waddr     = in_data.entry_index[IDX_W-1:0];
    ram_wdata     = in_data.entry_value;
    ram_raddr     = in_data.entry_index[IDX_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          state_nxt = S_FIN;
          case (in_data.opcode)
            OP_WRITE: begin
              ram_we         = in_rng;
              res_nxt.status = in_rng ? ST_OK : ST_RANGE;
            end
            OP_READ: begin
              if (in_rng) begin
                state_nxt = S_RDW;
              end else begin
                res_nxt.status = ST_RANGE;
              end
            end
            OP_FREE: begin
              if (in_rng) begin
                state_nxt = S_FREE;
                cur_nxt   = in_data.entry_index[IDX_W-1:0];
                byp_nxt   = 1'b0;
                freed_nxt = '0;
              end else begin
                res_nxt.status = ST_RANGE;
              end
            end
            default: begin
              state_nxt = S_SCAN;
              scan_nxt  = '0;
            end
          endcase
        end
      end
      S_RDW: begin
        res_nxt.read_value = ram_rdata;
        state_nxt          = S_FIN;
      end
      S_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = '0;
        ram_raddr = link[IDX_W-1:0];
        freed_nxt = freed_inc;
        res_nxt.freed_count = freed_inc;
        if (link == FAT_EOC) begin
          res_nxt.status = ST_OK;
          state_nxt      = S_FIN;
        end else if (link >= {2'b00, n_act}) begin
          res_nxt.status = ST_RANGE;
          state_nxt      = S_FIN;
        end else if (freed_inc == n_act) begin
          res_nxt.status = ST_NO_EOC;
          state_nxt      = S_FIN;
        end else begin
          cur_nxt = link[IDX_W-1:0];
          byp_nxt = (link[IDX_W-1:0] == cur_r);
        end
      end
      S_SCAN: begin
        ram_raddr = scan_r[IDX_W-1:0];
        if (pend_vld_r && (ram_rdata == '0)) begin
          res_nxt.status      = ST_OK;
          res_nxt.found_index = pend_idx_r;
          state_nxt           = S_FIN;
        end else if (!pend_vld_r && (scan_r == n_act)) begin
          res_nxt.status = ST_FULL;
          state_nxt      = S_FIN;
        end else if (scan_r < n_act) begin
          pend_vld_nxt = 1'b1;
          pend_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt     = scan_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bc_r        <= BLOCKS_MAX;
      pend_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bc_r        <= bc_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
    cur_r      <= cur_nxt;
    byp_r      <= byp_nxt;
    freed_r    <= freed_nxt;
    scan_r     <= scan_nxt;
    pend_idx_r <= pend_idx_nxt;
  end

endmodule
